// ===== rtl/core/dmp_pkg.sv =====
// Shared widths, register indexes, bus types and the sine table builder.
package dmp_pkg;

   // Defaults for the top level parameters.
   localparam int MAX_SAMPLES_DEF = 64;
   localparam int PHASE_BITS_DEF  = 10;

   // Fixed field widths.
   localparam int SAMPLE_W  = 16;
   localparam int BIN_W     = 6;
   localparam int X_W       = 13;
   localparam int Y_W       = 16;
   localparam int WIDTH_W   = 12;
   localparam int HEIGHT_W  = 12;
   localparam int SCALE_W   = 16;
   localparam int CFG_W     = 16;
   localparam int CFG_IDX_W = 2;
   // Accumulator: 17-bit sample times 16-bit twiddle over up to 126 samples.
   localparam int ACC_W     = 40;

   // Configuration register indexes.
   localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_OFFSET   = 2'd0;
   localparam logic [CFG_IDX_W-1:0] REG_PLOT_WIDTH      = 2'd1;
   localparam logic [CFG_IDX_W-1:0] REG_PLOT_HEIGHT     = 2'd2;
   localparam logic [CFG_IDX_W-1:0] REG_MAGNITUDE_SCALE = 2'd3;

   // Reset values of the configuration registers.
   localparam logic [WIDTH_W-1:0] PLOT_WIDTH_RST      = 12'd512;
   localparam logic [SCALE_W-1:0] MAGNITUDE_SCALE_RST = 16'd256;

   // Angle constants in Q30.
   localparam longint unsigned PI_Q30  = 64'd3373259426;
   localparam longint unsigned ONE_Q30 = 64'd1 << 30;

   // Sums of one bin handed from the MAC to the post-processing unit.
   typedef struct packed {
      logic [BIN_W-1:0]        bin;
      logic                    last;
      logic signed [ACC_W-1:0] acc_a;
      logic signed [ACC_W-1:0] acc_b;
   } bin_sum_type;

   // One entry of the quarter-wave sine table in Q1.15, evaluated at elaboration.
   function automatic logic [15:0] quarter_sine(input int unsigned j, input int unsigned pb);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned s;
      longint unsigned v;
      x  = (64'(j) * PI_Q30 + (64'd1 << (pb - 2))) >> (pb - 1);
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      t  = ONE_Q30 - (((x2 * t) >> 30) / 110);
      t  = ONE_Q30 - (((x2 * t) >> 30) / 72);
      t  = ONE_Q30 - (((x2 * t) >> 30) / 42);
      t  = ONE_Q30 - (((x2 * t) >> 30) / 20);
      t  = ONE_Q30 - (((x2 * t) >> 30) / 6);
      s  = (x * t) >> 30;
      v  = (s + 64'd16384) >> 15;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return v[15:0];
   endfunction

endpackage

// ===== rtl/core/dmp_cell.sv =====
// One sample cell of the circular sample chain.
module dmp_cell (
   input  logic                               clock,
   input  logic                               shift,
   input  logic signed [dmp_pkg::SAMPLE_W-1:0] data_in,
   output logic signed [dmp_pkg::SAMPLE_W-1:0] data_out
);

   logic signed [dmp_pkg::SAMPLE_W-1:0] data_ff;

   // Take the neighbor's sample whenever the chain moves.
   always_ff @(posedge clock) begin
      if (shift) begin
         data_ff <= data_in;
      end
   end

   assign data_out = data_ff;

endmodule

// ===== rtl/core/dmp_div.sv =====
// Restoring divider, one quotient bit per cycle.
module dmp_div #(
   parameter int DW = 24,
   parameter int VW = 7
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient,
   output logic [VW-1:0] remainder
);

   localparam int CNT_W = (DW > 1) ? $clog2(DW) : 1;

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DW-1:0]    num_ff;
   logic [VW-1:0]    rem_ff;
   logic [VW-1:0]    dvs_ff;
   logic [VW:0]      trial;
   logic             fits;

   // Bring down the next dividend bit and try to subtract.
   always_comb begin
      trial = {rem_ff, num_ff[DW-1]};
      fits  = (trial >= {1'b0, dvs_ff});
   end

   // Control: step counter and done pulse.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DW - 1);
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   // Datapath: partial remainder and quotient shift register.
   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         num_ff <= {num_ff[DW-2:0], fits};
         rem_ff <= fits ? VW'(trial - {1'b0, dvs_ff}) : trial[VW-1:0];
      end
   end

   assign done      = done_ff;
   assign quotient  = num_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/core/dmp_mac.sv =====
// Bin sequencer with twiddle lookup and the shared multiply-accumulate pipeline.
module dmp_mac #(
   parameter int MAX_SAMPLES = dmp_pkg::MAX_SAMPLES_DEF,
   parameter int PHASE_BITS  = dmp_pkg::PHASE_BITS_DEF,
   parameter int CW          = $clog2(MAX_SAMPLES + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [CW-1:0]                       n_samples,
   input  logic [PHASE_BITS-1:0]               frame_q,
   input  logic [CW-1:0]                       frame_r,
   input  logic signed [dmp_pkg::SAMPLE_W-1:0] offset,
   input  logic signed [dmp_pkg::SAMPLE_W-1:0] tap,
   input  logic                                post_ready,
   output logic                                rotate,
   output logic                                bin_valid,
   output dmp_pkg::bin_sum_type                bin_sum
);

   localparam int PB      = PHASE_BITS;
   localparam int QUARTER = 1 << (PB - 2);
   localparam int IW      = PB - 1;
   localparam int CTW     = $clog2(MAX_SAMPLES + 3);
   localparam int PW      = dmp_pkg::SAMPLE_W + 1 + dmp_pkg::SAMPLE_W;

   // Quarter-wave sine table.
   logic [15:0] sine_lut [QUARTER+1];

   for (genvar j = 0; j <= QUARTER; j++) begin : g_lut
      assign sine_lut[j] = dmp_pkg::quarter_sine(j, PB);
   end

   logic                                running_ff;
   logic [CTW-1:0]                      c_ff;
   logic [CTW-1:0]                      lo_ff;
   logic [CW-1:0]                       n_ff;
   logic [dmp_pkg::BIN_W-1:0]           k_ff;
   logic [PB-1:0]                       dq_ff;
   logic [CW-1:0]                       dr_ff;
   logic [PB-1:0]                       p_ff;
   logic [CW-1:0]                       r_ff;
   logic                                v1_ff;
   logic                                v2_ff;
   logic signed [dmp_pkg::SAMPLE_W:0]   x1_ff;
   logic signed [15:0]                  cos1_ff;
   logic signed [15:0]                  sin1_ff;
   logic signed [PW-1:0]                prod_c_ff;
   logic signed [PW-1:0]                prod_s_ff;
   logic signed [dmp_pkg::ACC_W-1:0]    acc_a_ff;
   logic signed [dmp_pkg::ACC_W-1:0]    acc_b_ff;
   logic                                bin_valid_ff;
   dmp_pkg::bin_sum_type                bin_sum_ff;

   logic                                v0;
   logic                                at_end;
   logic                                last_bin;
   logic [CW:0]                         r_sum;
   logic                                r_wrap;
   logic [CW-1:0]                       r_in;
   logic [PB-1:0]                       p_in;
   logic [CW:0]                         dr_sum;
   logic                                dr_wrap;
   logic [CW-1:0]                       dr_in;
   logic [PB-1:0]                       dq_in;
   logic [PB-1:0]                       ph_c;
   logic [IW-1:0]                       idx_s;
   logic [IW-1:0]                       idx_c;
   logic [15:0]                         val_s;
   logic [15:0]                         val_c;
   logic signed [15:0]                  sin_v;
   logic signed [15:0]                  cos_v;

   // Sample at the chain tap belongs to the frame while MAX_SAMPLES-N <= c < MAX_SAMPLES in the sweep.
   always_comb begin
      v0       = running_ff && (c_ff < CTW'(MAX_SAMPLES)) && (c_ff >= lo_ff);
      at_end   = (c_ff == CTW'(MAX_SAMPLES + 2));
      last_bin = (k_ff == dmp_pkg::BIN_W'(n_ff >> 1));
   end

   // Phase advance per sample: (p, r) tracks floor(n*k*2^PB/N) and its remainder.
   always_comb begin
      r_sum  = {1'b0, r_ff} + {1'b0, dr_ff};
      r_wrap = (r_sum >= {1'b0, n_ff});
      r_in   = r_wrap ? CW'(r_sum - {1'b0, n_ff}) : CW'(r_sum);
      p_in   = p_ff + dq_ff + PB'(r_wrap);
   end

   // Phase step per bin: (dq, dr) tracks floor(k*2^PB/N) and its remainder.
   always_comb begin
      dr_sum  = {1'b0, dr_ff} + {1'b0, frame_r};
      dr_wrap = (dr_sum >= {1'b0, n_ff});
      dr_in   = dr_wrap ? CW'(dr_sum - {1'b0, n_ff}) : CW'(dr_sum);
      dq_in   = dq_ff + frame_q + PB'(dr_wrap);
   end

   // Sine and cosine from the quarter-wave table with mirroring and sign.
   always_comb begin
      ph_c  = p_ff + PB'(QUARTER);
      idx_s = p_ff[PB-2] ? IW'(QUARTER) - {1'b0, p_ff[PB-3:0]} : {1'b0, p_ff[PB-3:0]};
      idx_c = ph_c[PB-2] ? IW'(QUARTER) - {1'b0, ph_c[PB-3:0]} : {1'b0, ph_c[PB-3:0]};
      val_s = sine_lut[idx_s];
      val_c = sine_lut[idx_c];
      sin_v = p_ff[PB-1] ? -$signed(val_s) : $signed(val_s);
      cos_v = ph_c[PB-1] ? -$signed(val_c) : $signed(val_c);
   end

   // Bin sequencer: one sweep of the chain per bin, then hand over the sums.
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff   <= 1'b0;
         c_ff         <= '0;
         k_ff         <= '0;
         bin_valid_ff <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
      end else begin
         bin_valid_ff <= 1'b0;
         v1_ff        <= v0;
         v2_ff        <= v1_ff;
         if (start) begin
            running_ff <= 1'b1;
            c_ff       <= '0;
            k_ff       <= '0;
         end else if (running_ff) begin
            if (!at_end) begin
               c_ff <= c_ff + 1'b1;
            end else if (post_ready) begin
               bin_valid_ff <= 1'b1;
               c_ff         <= '0;
               if (last_bin) begin
                  running_ff <= 1'b0;
               end else begin
                  k_ff <= k_ff + 1'b1;
               end
            end
         end
      end
   end

   // Phase registers and frame values.
   always_ff @(posedge clock) begin
      if (start) begin
         n_ff  <= n_samples;
         lo_ff <= CTW'(MAX_SAMPLES) - CTW'(n_samples);
         dq_ff <= '0;
         dr_ff <= '0;
         p_ff  <= '0;
         r_ff  <= '0;
      end else if (running_ff && at_end && post_ready) begin
         dq_ff <= dq_in;
         dr_ff <= dr_in;
         p_ff  <= '0;
         r_ff  <= '0;
      end else if (v0) begin
         p_ff <= p_in;
         r_ff <= r_in;
      end
   end

   // Multiply-accumulate pipeline: lookup, multiply, accumulate.
   always_ff @(posedge clock) begin
      x1_ff     <= $signed({tap[dmp_pkg::SAMPLE_W-1], tap})
                   - $signed({offset[dmp_pkg::SAMPLE_W-1], offset});
      cos1_ff   <= cos_v;
      sin1_ff   <= sin_v;
      prod_c_ff <= x1_ff * cos1_ff;
      prod_s_ff <= x1_ff * sin1_ff;
      if (running_ff && c_ff == '0) begin
         acc_a_ff <= '0;
         acc_b_ff <= '0;
      end else if (v2_ff) begin
         acc_a_ff <= acc_a_ff + dmp_pkg::ACC_W'(prod_c_ff);
         acc_b_ff <= acc_b_ff + dmp_pkg::ACC_W'(prod_s_ff);
      end
   end

   // Result register toward the post-processing unit.
   always_ff @(posedge clock) begin
      if (running_ff && at_end && post_ready) begin
         bin_sum_ff.bin   <= k_ff;
         bin_sum_ff.last  <= last_bin;
         bin_sum_ff.acc_a <= acc_a_ff;
         bin_sum_ff.acc_b <= acc_b_ff;
      end
   end

   assign rotate    = running_ff && (c_ff < CTW'(MAX_SAMPLES));
   assign bin_valid = bin_valid_ff;
   assign bin_sum   = bin_sum_ff;

endmodule

// ===== rtl/core/dmp_post.sv =====
// Per-bin post-processing: rounding, magnitude, scaling and plot coordinates.
module dmp_post #(
   parameter int CW = 7
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                frame_init,
   input  logic [CW-1:0]                       n_samples,
   input  logic [dmp_pkg::X_W-1:0]             step_q,
   input  logic [CW-1:0]                       step_r,
   input  logic [dmp_pkg::HEIGHT_W-1:0]        height,
   input  logic [dmp_pkg::SCALE_W-1:0]         scale,
   input  logic                                bin_valid,
   input  dmp_pkg::bin_sum_type                bin_sum,
   output logic                                ready,
   output logic                                rsp_strobe,
   output logic [dmp_pkg::BIN_W-1:0]           rsp_bin_index,
   output logic [dmp_pkg::X_W-1:0]             rsp_point_x,
   output logic signed [dmp_pkg::Y_W-1:0]      rsp_point_y,
   output logic                                rsp_last_point
);

   localparam int RW  = 24;
   localparam int SW  = 2 * RW;
   localparam int MW  = 17;
   localparam int PRW = dmp_pkg::SCALE_W + MW;

   localparam logic [2:0] P_IDLE = 3'd0;
   localparam logic [2:0] P_RND  = 3'd1;
   localparam logic [2:0] P_SQR  = 3'd2;
   localparam logic [2:0] P_SUM  = 3'd3;
   localparam logic [2:0] P_SQRT = 3'd4;
   localparam logic [2:0] P_DIV  = 3'd5;
   localparam logic [2:0] P_MUL  = 3'd6;
   localparam logic [2:0] P_OUT  = 3'd7;

   logic [2:0]                         state_ff;
   dmp_pkg::bin_sum_type               sum_ff;
   logic [dmp_pkg::X_W-1:0]            x_q_ff;
   logic [CW-1:0]                      x_r_ff;
   logic [dmp_pkg::X_W-1:0]            cap_x_ff;
   logic [RW-1:0]                      ra_ff;
   logic [RW-1:0]                      rb_ff;
   logic [SW-1:0]                      sa_ff;
   logic [SW-1:0]                      sb_ff;
   logic [SW-1:0]                      sq_rem_ff;
   logic [SW-1:0]                      sq_res_ff;
   logic [SW-1:0]                      sq_bit_ff;
   logic [MW-1:0]                      mag_ff;
   logic [PRW-1:0]                     prod_ff;
   logic                               strobe_ff;
   logic [dmp_pkg::BIN_W-1:0]          bin_ff;
   logic [dmp_pkg::X_W-1:0]            x_ff;
   logic signed [dmp_pkg::Y_W-1:0]     y_ff;
   logic                               last_ff;

   logic [CW-1:0]                      nm1;
   logic [CW:0]                        x_r_sum;
   logic                               x_wrap;
   logic [CW-1:0]                      x_r_in;
   logic [dmp_pkg::X_W-1:0]            x_q_in;
   logic                               neg_a;
   logic                               neg_b;
   logic [dmp_pkg::ACC_W-1:0]          abs_a;
   logic [dmp_pkg::ACC_W-1:0]          abs_b;
   logic [dmp_pkg::ACC_W-1:0]          rnd_a;
   logic [dmp_pkg::ACC_W-1:0]          rnd_b;
   logic [SW-1:0]                      sq_trial;
   logic                               sq_take;
   logic [SW-1:0]                      sq_rem_in;
   logic [SW-1:0]                      sq_res_in;
   logic                               div_start;
   logic                               div_done;
   logic [RW-1:0]                      div_q;
   logic [PRW-9:0]                     ys;
   logic [MW-1:0]                      ys_clip;
   logic signed [MW:0]                 y_full;
   logic signed [dmp_pkg::Y_W-1:0]     y_sat;

   // Horizontal position: (xq, xr) tracks floor(2*width*k/(N-1)) and its remainder.
   always_comb begin
      nm1     = n_samples - 1'b1;
      x_r_sum = {1'b0, x_r_ff} + {1'b0, step_r};
      x_wrap  = (x_r_sum >= {1'b0, nm1});
      x_r_in  = x_wrap ? CW'(x_r_sum - {1'b0, nm1}) : CW'(x_r_sum);
      x_q_in  = x_q_ff + step_q + dmp_pkg::X_W'(x_wrap);
   end

   // Round Q15 sums to integers; halves go away from zero above zero, toward it below.
   always_comb begin
      neg_a = sum_ff.acc_a[dmp_pkg::ACC_W-1];
      neg_b = sum_ff.acc_b[dmp_pkg::ACC_W-1];
      abs_a = neg_a ? -sum_ff.acc_a : sum_ff.acc_a;
      abs_b = neg_b ? -sum_ff.acc_b : sum_ff.acc_b;
      rnd_a = abs_a + (neg_a ? dmp_pkg::ACC_W'(16383) : dmp_pkg::ACC_W'(16384));
      rnd_b = abs_b + (neg_b ? dmp_pkg::ACC_W'(16383) : dmp_pkg::ACC_W'(16384));
   end

   // One step of the bit-pair square root.
   always_comb begin
      sq_trial  = sq_res_ff + sq_bit_ff;
      sq_take   = (sq_rem_ff >= sq_trial);
      sq_rem_in = sq_take ? sq_rem_ff - sq_trial : sq_rem_ff;
      sq_res_in = sq_take ? (sq_res_ff >> 1) + sq_bit_ff : (sq_res_ff >> 1);
      div_start = (state_ff == P_SQRT) && sq_bit_ff[0];
   end

   // Root divided by the frame length.
   dmp_div #(
      .DW (RW),
      .VW (CW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (sq_res_in[RW-1:0]),
      .divisor   (n_samples),
      .done      (div_done),
      .quotient  (div_q),
      .remainder ()
   );

   // Vertical position: height minus clipped scaled magnitude, saturated.
   always_comb begin
      ys      = prod_ff[PRW-1:8];
      ys_clip = (ys > (PRW-8)'(100000)) ? MW'(100000) : ys[MW-1:0];
      y_full  = $signed({{(MW + 1 - dmp_pkg::HEIGHT_W){1'b0}}, height})
                - $signed({1'b0, ys_clip});
      if (y_full < -$signed((MW+1)'(32768))) begin
         y_sat = {1'b1, {(dmp_pkg::Y_W-1){1'b0}}};
      end else if (y_full > $signed((MW+1)'(32767))) begin
         y_sat = {1'b0, {(dmp_pkg::Y_W-1){1'b1}}};
      end else begin
         y_sat = y_full[dmp_pkg::Y_W-1:0];
      end
   end

   // Sequencer over the post-processing steps.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= P_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         unique case (state_ff)
            P_IDLE: begin
               if (bin_valid) begin
                  state_ff <= P_RND;
               end
            end
            P_RND:  state_ff <= P_SQR;
            P_SQR:  state_ff <= P_SUM;
            P_SUM:  state_ff <= P_SQRT;
            P_SQRT: begin
               if (sq_bit_ff[0]) begin
                  state_ff <= P_DIV;
               end
            end
            P_DIV: begin
               if (div_done) begin
                  state_ff <= P_MUL;
               end
            end
            P_MUL:  state_ff <= P_OUT;
            P_OUT: begin
               strobe_ff <= 1'b1;
               state_ff  <= P_IDLE;
            end
            default: state_ff <= P_IDLE;
         endcase
      end
   end

   // Horizontal position stepper, restarted for each frame.
   always_ff @(posedge clock) begin
      if (frame_init) begin
         x_q_ff <= '0;
         x_r_ff <= '0;
      end else if (state_ff == P_IDLE && bin_valid) begin
         x_q_ff <= x_q_in;
         x_r_ff <= x_r_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (state_ff == P_IDLE && bin_valid) begin
         sum_ff   <= bin_sum;
         cap_x_ff <= x_q_ff;
      end
      if (state_ff == P_RND) begin
         ra_ff <= rnd_a[RW+14:15];
         rb_ff <= rnd_b[RW+14:15];
      end
      if (state_ff == P_SQR) begin
         sa_ff <= ra_ff * ra_ff;
         sb_ff <= rb_ff * rb_ff;
      end
      if (state_ff == P_SUM) begin
         sq_rem_ff <= sa_ff + sb_ff;
         sq_res_ff <= '0;
         sq_bit_ff <= SW'(1) << (SW - 2);
      end else if (state_ff == P_SQRT) begin
         sq_rem_ff <= sq_rem_in;
         sq_res_ff <= sq_res_in;
         sq_bit_ff <= sq_bit_ff >> 2;
      end
      if (state_ff == P_DIV && div_done) begin
         mag_ff <= div_q[MW-1:0];
      end
      if (state_ff == P_MUL) begin
         prod_ff <= scale * mag_ff;
      end
      if (state_ff == P_OUT) begin
         bin_ff  <= sum_ff.bin;
         x_ff    <= cap_x_ff;
         y_ff    <= y_sat;
         last_ff <= sum_ff.last;
      end
   end

   assign ready          = (state_ff == P_IDLE);
   assign rsp_strobe     = strobe_ff;
   assign rsp_bin_index  = bin_ff;
   assign rsp_point_x    = x_ff;
   assign rsp_point_y    = y_ff;
   assign rsp_last_point = last_ff;

endmodule

// ===== rtl/core/dft_magnitude_plot_points.sv =====
// Top level: sample chain, frame control, configuration registers and units.
// Loading: one sample per cycle; start is taken whenever busy is low. A frame of N >= 2
// samples keeps busy high through the two setup divisions, then N/2+1 bin periods (one
// sweep of the chain through the single multiply-accumulate unit, overlapped with the
// root and divide of the previous bin), then until the last bin is finished. Points
// leave one per bin, one cycle each.
// Synchronous reset clears control, the sample count and the registers; samples are not reset.
module dft_magnitude_plot_points #(
   parameter int MAX_SAMPLES = dmp_pkg::MAX_SAMPLES_DEF,
   parameter int PHASE_BITS  = dmp_pkg::PHASE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [dmp_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                                 req_frame_end,
   output logic                                 rsp_strobe,
   output logic [dmp_pkg::BIN_W-1:0]            rsp_bin_index,
   output logic [dmp_pkg::X_W-1:0]              rsp_point_x,
   output logic signed [dmp_pkg::Y_W-1:0]       rsp_point_y,
   output logic                                 rsp_last_point,
   input  logic                                 csr_write_enable,
   input  logic [dmp_pkg::CFG_IDX_W-1:0]        csr_index,
   input  logic [dmp_pkg::CFG_W-1:0]            csr_write_data
);

   localparam int CW  = $clog2(MAX_SAMPLES + 1);
   localparam int SDW = (PHASE_BITS + 1 > dmp_pkg::X_W) ? PHASE_BITS + 1 : dmp_pkg::X_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIVP = 2'd1;
   localparam logic [1:0] ST_DIVX = 2'd2;
   localparam logic [1:0] ST_RUN  = 2'd3;

   logic [1:0]                          state_ff;
   logic [CW-1:0]                       cnt_ff;
   logic [CW-1:0]                       n_ff;
   logic [PHASE_BITS-1:0]               frame_q_ff;
   logic [CW-1:0]                       frame_r_ff;
   logic [dmp_pkg::X_W-1:0]             x_q_ff;
   logic [CW-1:0]                       x_r_ff;
   logic signed [dmp_pkg::SAMPLE_W-1:0] offset_ff;
   logic [dmp_pkg::WIDTH_W-1:0]         width_ff;
   logic [dmp_pkg::HEIGHT_W-1:0]        height_ff;
   logic [dmp_pkg::SCALE_W-1:0]         scale_ff;

   logic                                accept;
   logic                                room;
   logic [CW-1:0]                       n_in;
   logic                                go;
   logic                                div_start;
   logic [SDW-1:0]                      div_dividend;
   logic [CW-1:0]                       div_divisor;
   logic                                div_done;
   logic [SDW-1:0]                      div_q;
   logic [CW-1:0]                       div_r;
   logic                                mac_start;
   logic                                rotate;
   logic                                shift;
   logic                                post_ready;
   logic                                bin_valid;
   dmp_pkg::bin_sum_type                bin_sum;
   logic signed [dmp_pkg::SAMPLE_W-1:0] cell_data [MAX_SAMPLES];
   logic signed [dmp_pkg::SAMPLE_W-1:0] cell0_in;

   // Input transaction and frame length.
   always_comb begin
      accept    = start && (state_ff == ST_IDLE);
      room      = (cnt_ff < CW'(MAX_SAMPLES));
      n_in      = room ? cnt_ff + 1'b1 : cnt_ff;
      go        = accept && req_frame_end && (n_in >= CW'(2));
      mac_start = (state_ff == ST_DIVX) && div_done;
   end

   // Frame setup divisions: 2^PHASE_BITS / N, then 2*width / (N-1).
   always_comb begin
      div_start    = go || ((state_ff == ST_DIVP) && div_done);
      div_dividend = (state_ff == ST_IDLE) ? (SDW'(1) << PHASE_BITS)
                                           : SDW'({width_ff, 1'b0});
      div_divisor  = (state_ff == ST_IDLE) ? n_in : n_ff - 1'b1;
   end

   dmp_div #(
      .DW (SDW),
      .VW (CW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // Frame control.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         if (accept) begin
            cnt_ff <= req_frame_end ? '0 : n_in;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (go) begin
                  state_ff <= ST_DIVP;
               end
            end
            ST_DIVP: begin
               if (div_done) begin
                  state_ff <= ST_DIVX;
               end
            end
            ST_DIVX: begin
               if (div_done) begin
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (rsp_strobe && rsp_last_point) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Frame values latched during setup.
   always_ff @(posedge clock) begin
      if (go) begin
         n_ff <= n_in;
      end
      if (state_ff == ST_DIVP && div_done) begin
         frame_q_ff <= div_q[PHASE_BITS-1:0];
         frame_r_ff <= div_r;
      end
      if (state_ff == ST_DIVX && div_done) begin
         x_q_ff <= div_q[dmp_pkg::X_W-1:0];
         x_r_ff <= div_r;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         width_ff  <= dmp_pkg::PLOT_WIDTH_RST;
         height_ff <= '0;
         scale_ff  <= dmp_pkg::MAGNITUDE_SCALE_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            dmp_pkg::REG_SAMPLE_OFFSET:   offset_ff <= $signed(csr_write_data);
            dmp_pkg::REG_PLOT_WIDTH:      width_ff  <= csr_write_data[dmp_pkg::WIDTH_W-1:0];
            dmp_pkg::REG_PLOT_HEIGHT:     height_ff <= csr_write_data[dmp_pkg::HEIGHT_W-1:0];
            dmp_pkg::REG_MAGNITUDE_SCALE: scale_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Circular sample chain: loads shift in at the head, sweeps rotate the tail back.
   assign shift    = (accept && room) || rotate;
   assign cell0_in = rotate ? cell_data[MAX_SAMPLES-1] : req_sample;

   for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
      if (i == 0) begin : g_head
         dmp_cell u_cell (
            .clock    (clock),
            .shift    (shift),
            .data_in  (cell0_in),
            .data_out (cell_data[i])
         );
      end else begin : g_body
         dmp_cell u_cell (
            .clock    (clock),
            .shift    (shift),
            .data_in  (cell_data[i-1]),
            .data_out (cell_data[i])
         );
      end
   end

   dmp_mac #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .PHASE_BITS  (PHASE_BITS),
      .CW          (CW)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .start      (mac_start),
      .n_samples  (n_ff),
      .frame_q    (frame_q_ff),
      .frame_r    (frame_r_ff),
      .offset     (offset_ff),
      .tap        (cell_data[MAX_SAMPLES-1]),
      .post_ready (post_ready),
      .rotate     (rotate),
      .bin_valid  (bin_valid),
      .bin_sum    (bin_sum)
   );

   dmp_post #(
      .CW (CW)
   ) u_post (
      .clock          (clock),
      .reset          (reset),
      .frame_init     (mac_start),
      .n_samples      (n_ff),
      .step_q         (x_q_ff),
      .step_r         (x_r_ff),
      .height         (height_ff),
      .scale          (scale_ff),
      .bin_valid      (bin_valid),
      .bin_sum        (bin_sum),
      .ready          (post_ready),
      .rsp_strobe     (rsp_strobe),
      .rsp_bin_index  (rsp_bin_index),
      .rsp_point_x    (rsp_point_x),
      .rsp_point_y    (rsp_point_y),
      .rsp_last_point (rsp_last_point)
   );

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== rtl/core/dmp_checker.sv =====
// Port-level checks of the busy and result strobe behavior, bound to the top level.
module dmp_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 start,
   input logic                                 busy,
   input logic signed [dmp_pkg::SAMPLE_W-1:0]  req_sample,
   input logic                                 req_frame_end,
   input logic                                 rsp_strobe,
   input logic [dmp_pkg::BIN_W-1:0]            rsp_bin_index,
   input logic [dmp_pkg::X_W-1:0]              rsp_point_x,
   input logic signed [dmp_pkg::Y_W-1:0]       rsp_point_y,
   input logic                                 rsp_last_point,
   input logic                                 csr_write_enable,
   input logic [dmp_pkg::CFG_IDX_W-1:0]        csr_index,
   input logic [dmp_pkg::CFG_W-1:0]            csr_write_data
);

   // Points only come out while a frame is being processed.
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result transaction while not busy");

   // The last point of a frame releases the block.
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_point |=> !busy)
      else $error("busy after last point");

   // More points follow a point that is not the last one.
   a_more_points: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_point |=> busy)
      else $error("frame ended without last point");

   // A result strobe is never directly followed by another.
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("back-to-back result transactions");

   // A sample that does not end a frame leaves the block idle in the cycle after it is taken.
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_frame_end |=> !busy)
      else $error("busy after a plain sample");

endmodule

bind dft_magnitude_plot_points dmp_checker u_dmp_checker (.*);

// ===== sim/tb.sv =====
// Self-checking testbench for the DFT magnitude plot point block.
`timescale 1ns / 100ps

module tb;

   localparam int SAMPLE_W  = dmp_pkg::SAMPLE_W;
   localparam int BIN_W     = dmp_pkg::BIN_W;
   localparam int X_W       = dmp_pkg::X_W;
   localparam int Y_W       = dmp_pkg::Y_W;
   localparam int WIDTH_W   = dmp_pkg::WIDTH_W;
   localparam int HEIGHT_W  = dmp_pkg::HEIGHT_W;
   localparam int SCALE_W   = dmp_pkg::SCALE_W;
   localparam int CFG_W     = dmp_pkg::CFG_W;
   localparam int CFG_IDX_W = dmp_pkg::CFG_IDX_W;
   localparam int PHASE_BITS_DEF = dmp_pkg::PHASE_BITS_DEF;
   localparam longint unsigned PI_Q30  = dmp_pkg::PI_Q30;
   localparam longint unsigned ONE_Q30 = dmp_pkg::ONE_Q30;
   localparam logic [WIDTH_W-1:0] PLOT_WIDTH_RST      = dmp_pkg::PLOT_WIDTH_RST;
   localparam logic [SCALE_W-1:0] MAGNITUDE_SCALE_RST = dmp_pkg::MAGNITUDE_SCALE_RST;
   localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_OFFSET   = dmp_pkg::REG_SAMPLE_OFFSET;
   localparam logic [CFG_IDX_W-1:0] REG_PLOT_WIDTH      = dmp_pkg::REG_PLOT_WIDTH;
   localparam logic [CFG_IDX_W-1:0] REG_PLOT_HEIGHT     = dmp_pkg::REG_PLOT_HEIGHT;
   localparam logic [CFG_IDX_W-1:0] REG_MAGNITUDE_SCALE = dmp_pkg::REG_MAGNITUDE_SCALE;

   localparam int FRAME_DEPTH = dmp_pkg::MAX_SAMPLES_DEF;
   localparam int QUARTER     = (1 << PHASE_BITS_DEF) / 4;
   localparam int IDLE_LIMIT  = 20000;

   typedef struct {
      logic [BIN_W-1:0]        bin;
      logic [X_W-1:0]          x;
      logic signed [Y_W-1:0]   y;
      logic                    last;
   } plot_point_type;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       frame_end;
      bit                         typed;
      logic [X_W-1:0]             x1;
      logic signed [Y_W-1:0]      y0;
      logic signed [Y_W-1:0]      y1;
   } stim_row_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic signed [SAMPLE_W-1:0]  req_sample = '0;
   logic                        req_frame_end = 1'b0;
   logic                        rsp_strobe;
   logic [BIN_W-1:0]            rsp_bin_index;
   logic [X_W-1:0]              rsp_point_x;
   logic signed [Y_W-1:0]       rsp_point_y;
   logic                        rsp_last_point;
   logic                        csr_write_enable = 1'b0;
   logic [CFG_IDX_W-1:0]        csr_index = '0;
   logic [CFG_W-1:0]            csr_write_data = '0;

   // Model state kept by the testbench.
   plot_point_type              expected_points[$];
   logic signed [SAMPLE_W-1:0]  frame_buf[FRAME_DEPTH];
   int                          frame_len = 0;
   int                          sine_lut[QUARTER+1];
   logic signed [15:0]          cur_offset = '0;
   logic [WIDTH_W-1:0]          cur_width = PLOT_WIDTH_RST;
   logic [HEIGHT_W-1:0]         cur_height = '0;
   logic [SCALE_W-1:0]          cur_scale = MAGNITUDE_SCALE_RST;

   int errors = 0;
   int frames_done = 0;
   int points_seen = 0;
   int items_sent = 0;
   int cfg_writes = 0;
   int idle_cycles = 0;

   dft_magnitude_plot_points DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_sample(req_sample), .req_frame_end(req_frame_end),
      .rsp_strobe(rsp_strobe), .rsp_bin_index(rsp_bin_index),
      .rsp_point_x(rsp_point_x), .rsp_point_y(rsp_point_y),
      .rsp_last_point(rsp_last_point), .csr_write_enable(csr_write_enable),
      .csr_index(csr_index), .csr_write_data(csr_write_data)
   );

   always #2 clock = ~clock;

   // Quarter-wave sine table built from a truncated Taylor series in Q30.
   initial begin
      longint unsigned ang, ang2, t, s, v;
      for (int j = 0; j <= QUARTER; j++) begin
         ang  = (longint'(j) * PI_Q30 + QUARTER) / (2 * QUARTER);
         ang2 = (ang * ang) >> 30;
         t    = ONE_Q30;
         t    = ONE_Q30 - (((ang2 * t) >> 30) / 110);
         t    = ONE_Q30 - (((ang2 * t) >> 30) / 72);
         t    = ONE_Q30 - (((ang2 * t) >> 30) / 42);
         t    = ONE_Q30 - (((ang2 * t) >> 30) / 20);
         t    = ONE_Q30 - (((ang2 * t) >> 30) / 6);
         s    = (ang * t) >> 30;
         v    = (s + 16384) >> 15;
         sine_lut[j] = (v > 32767) ? 32767 : int'(v);
      end
   end

   function automatic longint twiddle(int unsigned p);
      int unsigned q, r, idx;
      p   = p & ((1 << PHASE_BITS_DEF) - 1);
      q   = p >> (PHASE_BITS_DEF - 2);
      r   = p & (QUARTER - 1);
      idx = q[0] ? (QUARTER - r) : r;
      return q[1] ? -longint'(sine_lut[idx]) : longint'(sine_lut[idx]);
   endfunction

   function automatic longint round_sum(longint v);
      return (v >= 0) ? (v + 16384) / 32768 : -((-v + 16383) / 32768);
   endfunction

   function automatic longint floor_sqrt(longint unsigned v);
      longint unsigned res, cand;
      res = 0;
      for (int b = 31; b >= 0; b--) begin
         cand = res | (longint'(1) << b);
         if (cand * cand <= v) begin
            res = cand;
         end
      end
      return res;
   endfunction

   // Appends one point at the tail of the expected queue.
   function automatic void add_expected(plot_point_type pt);
      expected_points.insert(expected_points.size(), pt);
   endfunction

   // Computes the plot points of the buffered frame and queues them.
   function automatic void predict_spectrum(int n_samp);
      longint a, b, ai, bi, xn, mag, xs, ys, y;
      int unsigned m, p;
      plot_point_type pt;
      for (int k = 0; k <= n_samp / 2; k++) begin
         a = 0;
         b = 0;
         for (int n = 0; n < n_samp; n++) begin
            xn = longint'(frame_buf[n]) - longint'(cur_offset);
            m  = (n * k) % n_samp;
            p  = (m << PHASE_BITS_DEF) / n_samp;
            a += xn * twiddle(p + QUARTER);
            b += xn * twiddle(p);
         end
         ai  = round_sum(a);
         bi  = round_sum(b);
         mag = floor_sqrt(ai * ai + bi * bi) / n_samp;
         xs  = (longint'(cur_width) * 2 * k) / (n_samp - 1);
         ys  = (longint'(cur_scale) * mag) >>> 8;
         if (ys > 100000) begin
            ys = 100000;
         end
         y = longint'(cur_height) - ys;
         if (y < -32768) y = -32768;
         if (y > 32767) y = 32767;
         pt.bin  = k[BIN_W-1:0];
         pt.x    = xs[X_W-1:0];
         pt.y    = y[Y_W-1:0];
         pt.last = (k == n_samp / 2);
         add_expected(pt);
      end
   endfunction

   // Compare every result transaction with the oldest expected point.
   always @(posedge clock) begin
      plot_point_type exp_pt;
      if (!reset && rsp_strobe) begin
         points_seen++;
         if (expected_points.size() == 0) begin
            $error("unexpected point: bin %0d x %0d y %0d", rsp_bin_index, rsp_point_x,
                   rsp_point_y);
            errors++;
         end else begin
            exp_pt = expected_points.pop_front();
            if (rsp_bin_index !== exp_pt.bin) begin
               $error("bin_index: expected %0d, got %0d", exp_pt.bin, rsp_bin_index);
               errors++;
            end
            if (rsp_point_x !== exp_pt.x) begin
               $error("point_x: expected %0d, got %0d", exp_pt.x, rsp_point_x);
               errors++;
            end
            if (rsp_point_y !== exp_pt.y) begin
               $error("point_y: expected %0d, got %0d", exp_pt.y, rsp_point_y);
               errors++;
            end
            if (rsp_last_point !== exp_pt.last) begin
               $error("last_point: expected %0d, got %0d", exp_pt.last, rsp_last_point);
               errors++;
            end
         end
      end
   end

   // Watchdog on cycles without any accepted transaction.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("dft_magnitude_plot_points test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 95) return $urandom_range(3, 1);
      return $urandom_range(200, 20);
   endfunction

   // Sends one sample transaction and updates the predictor once it is taken.
   task automatic send_sample(input logic signed [15:0] s, input logic fe, input bit typed,
                              input logic [X_W-1:0] x1, input logic signed [15:0] y0,
                              input logic signed [15:0] y1, input int gap);
      plot_point_type pt;
      start         <= 1'b1;
      req_sample    <= s;
      req_frame_end <= fe;
      do @(posedge clock); while (busy);
      items_sent++;
      if (frame_len < FRAME_DEPTH) begin
         frame_buf[frame_len] = s;
         frame_len++;
      end
      if (fe) begin
         if (frame_len >= 2) begin
            frames_done++;
            if (typed) begin
               pt = '{bin: 0, x: 0, y: y0, last: 1'b0};
               add_expected(pt);
               pt = '{bin: 1, x: x1, y: y1, last: 1'b1};
               add_expected(pt);
            end else begin
               predict_spectrum(frame_len);
            end
         end
         frame_len = 0;
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Waits until every expected point has arrived and the block is idle.
   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (expected_points.size() != 0 || busy);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(posedge clock);
      cfg_writes++;
      case (idx)
         REG_SAMPLE_OFFSET:   cur_offset = val;
         REG_PLOT_WIDTH:      cur_width  = val[WIDTH_W-1:0];
         REG_PLOT_HEIGHT:     cur_height = val[HEIGHT_W-1:0];
         REG_MAGNITUDE_SCALE: cur_scale  = val;
         default: ;
      endcase
   endtask

   task automatic send_frame(input int len, input int style);
      logic signed [15:0] s, base;
      base = 16'($urandom);
      for (int i = 0; i < len; i++) begin
         case (style)
            0: s = 16'($urandom);
            1: s = base + $signed(16'($urandom_range(15))) - 16'sd8;
            default: s = (i % 2) ? 16'sh7FFF : 16'sh8000;
         endcase
         send_sample(s, i == len - 1, 1'b0, '0, '0, '0, pick_gap());
      end
   endtask

   stim_row_type directed[] = '{
      // All-zero frame of two samples: flat spectrum at the reset height.
      '{16'sd0, 1'b0, 1'b0, 13'd0, 16'sd0, 16'sd0},
      '{16'sd0, 1'b1, 1'b1, 13'd1024, 16'sd0, 16'sd0},
      // Short frame of one sample emits nothing.
      '{16'sd5, 1'b1, 1'b1, 13'd0, 16'sd0, 16'sd0},
      // Alternating full-scale extremes.
      '{16'sh7FFF, 1'b0, 1'b0, 13'd0, 16'sd0, 16'sd0},
      '{16'sh8000, 1'b0, 1'b0, 13'd0, 16'sd0, 16'sd0},
      '{16'sh7FFF, 1'b0, 1'b0, 13'd0, 16'sd0, 16'sd0},
      '{16'sh8000, 1'b1, 1'b0, 13'd0, 16'sd0, 16'sd0},
      // Odd-length frame with mixed values.
      '{16'sd1000, 1'b0, 1'b0, 13'd0, 16'sd0, 16'sd0},
      '{-16'sd1000, 1'b0, 1'b0, 13'd0, 16'sd0, 16'sd0},
      '{16'sd12345, 1'b0, 1'b0, 13'd0, 16'sd0, 16'sd0},
      '{16'sh5555, 1'b0, 1'b0, 13'd0, 16'sd0, 16'sd0},
      '{16'shAAAA, 1'b1, 1'b0, 13'd0, 16'sd0, 16'sd0},
      // Constant frame: energy only in bin zero.
      '{16'sd300, 1'b0, 1'b0, 13'd0, 16'sd0, 16'sd0},
      '{16'sd300, 1'b0, 1'b0, 13'd0, 16'sd0, 16'sd0},
      '{16'sd300, 1'b1, 1'b0, 13'd0, 16'sd0, 16'sd0}
   };

   initial begin
      int phase_items;
      int r;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table at the reset configuration.
      foreach (directed[i]) begin
         send_sample(directed[i].sample, directed[i].frame_end, directed[i].typed,
                     directed[i].x1, directed[i].y0, directed[i].y1, pick_gap());
      end
      wait_drained();

      // Random phases, each with its own register setting.
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin
               write_reg(REG_SAMPLE_OFFSET, 16'h0000);
               write_reg(REG_PLOT_WIDTH, 16'd512);
               write_reg(REG_PLOT_HEIGHT, 16'd0);
               write_reg(REG_MAGNITUDE_SCALE, 16'd256);
            end
            1: begin
               write_reg(REG_SAMPLE_OFFSET, 16'h8000);
               write_reg(REG_PLOT_WIDTH, 16'd4095);
               write_reg(REG_PLOT_HEIGHT, 16'd4095);
               write_reg(REG_MAGNITUDE_SCALE, 16'hFFFF);
            end
            2: begin
               write_reg(REG_SAMPLE_OFFSET, 16'h7FFF);
               write_reg(REG_PLOT_WIDTH, 16'd0);
               write_reg(REG_PLOT_HEIGHT, 16'd0);
               write_reg(REG_MAGNITUDE_SCALE, 16'd0);
            end
            default: begin
               write_reg(REG_SAMPLE_OFFSET, 16'($urandom));
               write_reg(REG_PLOT_WIDTH, 16'($urandom_range(4095)));
               write_reg(REG_PLOT_HEIGHT, 16'($urandom_range(4095)));
               write_reg(REG_MAGNITUDE_SCALE, 16'($urandom));
            end
         endcase
         csr_write_enable <= 1'b0;
         @(posedge clock);

         phase_items = items_sent;
         while (items_sent - phase_items < 38) begin
            r = $urandom_range(99);
            if (r < 80) send_frame($urandom_range(12, 2), $urandom_range(2));
            else if (r < 88) send_frame(1, 0);
            else if (r < 94) send_frame($urandom_range(40, 13), 0);
            else if (r < 97) send_frame(FRAME_DEPTH, $urandom_range(2));
            else send_frame($urandom_range(FRAME_DEPTH + 6, FRAME_DEPTH + 1), 0);
            // Occasionally hold the sender until the block has drained.
            if ($urandom_range(9) == 0) begin
               wait_drained();
            end
         end
         wait_drained();
      end

      repeat (100) @(posedge clock);
      $display("Covered %0d sample transactions, %0d frames and %0d points", items_sent,
               frames_done, points_seen);
      $display("across 9 register settings using %0d register writes.", cfg_writes);
      if (errors == 0 && expected_points.size() == 0) begin
         $display("dft_magnitude_plot_points test passed");
      end else begin
         $display("dft_magnitude_plot_points test failed");
      end
      $finish;
   end

endmodule

// ===== dft_magnitude_plot_points.f =====
rtl/core/dmp_pkg.sv
rtl/core/dmp_cell.sv
rtl/core/dmp_div.sv
rtl/core/dmp_mac.sv
rtl/core/dmp_post.sv
rtl/core/dft_magnitude_plot_points.sv
rtl/core/dmp_checker.sv
sim/tb.sv
